FILE: hdl/uhpe_pkg.sv
// Package for the URL host and port extractor.
// Holds character codes, status codes, phase and word types, and helper functions.
// Has no dependencies.
package uhpe_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    localparam logic [15:0] PORT_MAX = 16'hFFFF;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SCHEME = 2'd1;
    localparam logic [1:0] ST_NO_SLASH  = 2'd2;
    localparam logic [1:0] ST_BAD_ENC   = 2'd3;

    localparam logic KIND_HOST    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_SCHEME = 3'd0,
        PH_SLASH1 = 3'd1,
        PH_SLASH2 = 3'd2,
        PH_HOST   = 3'd3,
        PH_PORT   = 3'd4,
        PH_TAIL   = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic        seen_any_char;
        logic [1:0]  escape_count;
        logic [3:0]  high_nibble;
        logic [15:0] port_accum;
        logic        port_digits_ended;
        logic [1:0]  error_code;
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [7:0]  host_char;
        logic [15:0] port_number;
        logic [1:0]  status;
        logic        run_end;
    } t_word;

    localparam t_state STATE_RESET = '{
        phase: PH_SCHEME, seen_any_char: 1'b0, escape_count: ESC_NONE,
        high_nibble: 4'd0, port_accum: 16'd0, port_digits_ended: 1'b0,
        error_code: ST_OK
    };

    function automatic logic [1:0] keep_error(logic [1:0] cur, logic [1:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    function automatic t_state finish_string(t_state s);
        t_state r;
        r = s;
        if (s.phase == PH_SCHEME) begin
            r.error_code = keep_error(s.error_code, ST_NO_SCHEME);
        end else if (s.phase == PH_SLASH1 || s.phase == PH_SLASH2) begin
            r.error_code = keep_error(s.error_code, ST_NO_SLASH);
        end else if (s.phase == PH_HOST && s.escape_count != ESC_NONE) begin
            r.error_code = keep_error(s.error_code, ST_BAD_ENC);
        end
        r.escape_count = ESC_NONE;
        r.phase = PH_DONE;
        return r;
    endfunction

endpackage

FILE: hdl/uhpe_if.sv
// Valid/ready channel interfaces for URL bytes and result words.
// Payload widths match those of uhpe_pkg, but it has no dependencies.
interface uhpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] url_byte;
    logic       end_of_url;

    modport source (output valid, output url_byte, output end_of_url, input ready);
    modport sink (input valid, input url_byte, input end_of_url, output ready);
endinterface

interface uhpe_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  host_char;
    logic [15:0] port_number;
    logic [1:0]  status;
    logic        run_end;

    modport source (output valid, output kind, output host_char, output port_number,
                    output status, output run_end, input ready);
    modport sink (input valid, input kind, input host_char, input port_number,
                  input status, input run_end, output ready);
endinterface

FILE: hdl/uhpe_step.sv
// Per-byte parser step: next state and up to two result words for one URL byte.
// Depends on uhpe_pkg.
module uhpe_step (
    input  uhpe_pkg::t_state i_state,
    input  logic [7:0]       i_url_byte,
    input  logic             i_end_of_url,
    output uhpe_pkg::t_state o_next,
    output logic [1:0]       o_count,
    output uhpe_pkg::t_word  o_word0,
    output uhpe_pkg::t_word  o_word1
);

    uhpe_pkg::t_state s;
    uhpe_pkg::t_state fin;
    uhpe_pkg::t_word  host_w;
    uhpe_pkg::t_word  sum_w;
    logic             emit;
    logic [7:0]       c;
    logic [7:0]       d;
    logic             hex_ok;
    logic [3:0]       hex_v;
    logic [19:0]      p;

    always_comb begin
        s = i_state;
        emit = 1'b0;
        d = 8'd0;

        c = (i_url_byte inside {[8'h41:8'h5A]}) ? i_url_byte + uhpe_pkg::CASE_DELTA
                                                 : i_url_byte;
        hex_ok = 1'b1;
        if (c inside {[8'h30:8'h39]}) begin
            hex_v = c[3:0];
        end else if (c inside {[8'h61:8'h66]}) begin
            hex_v = c[3:0] + 4'd9;
        end else begin
            hex_v = 4'd0;
            hex_ok = 1'b0;
        end

        p = ({4'd0, i_state.port_accum} << 3) + ({4'd0, i_state.port_accum} << 1)
            + {16'd0, i_url_byte[3:0]};

        if (i_url_byte == uhpe_pkg::CH_NUL && i_state.phase != uhpe_pkg::PH_DONE) begin
            s = uhpe_pkg::finish_string(i_state);
        end else begin
            case (i_state.phase)
                uhpe_pkg::PH_SCHEME: begin
                    if (i_url_byte == uhpe_pkg::CH_COLON) begin
                        if (!i_state.seen_any_char) begin
                            s.error_code = uhpe_pkg::keep_error(i_state.error_code,
                                                                uhpe_pkg::ST_NO_SCHEME);
                            s.phase = uhpe_pkg::PH_DONE;
                        end else begin
                            s.phase = uhpe_pkg::PH_SLASH1;
                        end
                    end else begin
                        s.seen_any_char = 1'b1;
                    end
                end
                uhpe_pkg::PH_SLASH1, uhpe_pkg::PH_SLASH2: begin
                    if (i_url_byte == uhpe_pkg::CH_SLASH) begin
                        s.phase = (i_state.phase == uhpe_pkg::PH_SLASH1) ?
                                  uhpe_pkg::PH_SLASH2 : uhpe_pkg::PH_HOST;
                    end else begin
                        s.error_code = uhpe_pkg::keep_error(i_state.error_code,
                                                            uhpe_pkg::ST_NO_SLASH);
                        s.phase = uhpe_pkg::PH_DONE;
                    end
                end
                uhpe_pkg::PH_HOST: begin
                    if (i_url_byte == uhpe_pkg::CH_SLASH
                            || i_url_byte == uhpe_pkg::CH_COLON) begin
                        if (i_state.escape_count != uhpe_pkg::ESC_NONE) begin
                            s.error_code = uhpe_pkg::keep_error(i_state.error_code,
                                                                uhpe_pkg::ST_BAD_ENC);
                        end
                        s.escape_count = uhpe_pkg::ESC_NONE;
                        s.phase = (i_url_byte == uhpe_pkg::CH_SLASH) ?
                                  uhpe_pkg::PH_TAIL : uhpe_pkg::PH_PORT;
                    end else if (i_state.escape_count == uhpe_pkg::ESC_NONE) begin
                        if (c == uhpe_pkg::CH_PERCENT) begin
                            s.escape_count = uhpe_pkg::ESC_PCT;
                        end else if (i_state.error_code == uhpe_pkg::ST_OK) begin
                            emit = 1'b1;
                            d = c;
                        end
                    end else if (!hex_ok) begin
                        s.error_code = uhpe_pkg::keep_error(i_state.error_code,
                                                            uhpe_pkg::ST_BAD_ENC);
                        s.escape_count = uhpe_pkg::ESC_NONE;
                    end else if (i_state.escape_count == uhpe_pkg::ESC_PCT) begin
                        s.high_nibble = hex_v;
                        s.escape_count = uhpe_pkg::ESC_DIGIT;
                    end else begin
                        s.escape_count = uhpe_pkg::ESC_NONE;
                        if ({i_state.high_nibble, hex_v} == uhpe_pkg::CH_NUL) begin
                            s.error_code = uhpe_pkg::keep_error(i_state.error_code,
                                                                uhpe_pkg::ST_BAD_ENC);
                        end else if (i_state.error_code == uhpe_pkg::ST_OK) begin
                            emit = 1'b1;
                            d = {i_state.high_nibble, hex_v};
                        end
                    end
                end
                uhpe_pkg::PH_PORT: begin
                    if (i_url_byte == uhpe_pkg::CH_SLASH) begin
                        s.phase = uhpe_pkg::PH_TAIL;
                    end else if ((i_url_byte inside {[8'h30:8'h39]})
                                 && !i_state.port_digits_ended) begin
                        s.port_accum = (p > {4'd0, uhpe_pkg::PORT_MAX}) ?
                                       uhpe_pkg::PORT_MAX : p[15:0];
                    end else begin
                        s.port_digits_ended = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        fin = uhpe_pkg::finish_string(s);

        host_w.kind = uhpe_pkg::KIND_HOST;
        host_w.host_char = d;
        host_w.port_number = 16'd0;
        host_w.status = uhpe_pkg::ST_OK;
        host_w.run_end = !i_end_of_url;

        sum_w.kind = uhpe_pkg::KIND_SUMMARY;
        sum_w.host_char = 8'd0;
        sum_w.port_number = s.port_accum;
        sum_w.status = fin.error_code;
        sum_w.run_end = 1'b1;

        if (i_end_of_url) begin
            o_next = uhpe_pkg::STATE_RESET;
        end else begin
            o_next = s;
        end

        o_count = {1'b0, emit} + {1'b0, i_end_of_url};
        o_word0 = emit ? host_w : sum_w;
        o_word1 = sum_w;
    end

endmodule

FILE: hdl/url_host_port_extractor_unit.sv
// Top level of the URL host and port extractor: parser state and a two-word result queue.
// Depends on uhpe_pkg, uhpe_if and uhpe_step.
//
//  Channel  | Dir | Fields                                         | Word
//  i_url    | in  | url_byte, end_of_url                           | one URL character
//  o_res    | out | kind, host_char, port_number, status, run_end  | host byte or summary
//
// Each byte is parsed in the cycle it is accepted; its words appear in the cycle after.
// A byte is taken every cycle while one word or less is waiting and the sink keeps up.
// A byte that causes two words holds the next byte back until the sink has taken one.
// Reset is synchronous and active low; it clears the parser state and empties the queue.
module url_host_port_extractor_unit (
    input logic          i_clk,
    input logic          i_rst_n,
    uhpe_in_if.sink      i_url,
    uhpe_out_if.source   o_res
);

    uhpe_pkg::t_state r_state;
    uhpe_pkg::t_state n_state;
    uhpe_pkg::t_word  r_q [uhpe_pkg::QUEUE_DEPTH];
    uhpe_pkg::t_word  n_q [uhpe_pkg::QUEUE_DEPTH];
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    uhpe_pkg::t_state step_next;
    logic [1:0]       step_count;
    uhpe_pkg::t_word  step_w0;
    uhpe_pkg::t_word  step_w1;
    logic             pop;
    logic             push;

    uhpe_step u_step (
        .i_state      (r_state),
        .i_url_byte   (i_url.url_byte),
        .i_end_of_url (i_url.end_of_url),
        .o_next       (step_next),
        .o_count      (step_count),
        .o_word0      (step_w0),
        .o_word1      (step_w1)
    );

    assign i_url.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_res.ready);
    assign push = i_url.valid && i_url.ready;
    assign pop = o_res.valid && o_res.ready;

    assign o_res.valid       = (r_cnt != 2'd0);
    assign o_res.kind        = r_q[0].kind;
    assign o_res.host_char   = r_q[0].host_char;
    assign o_res.port_number = r_q[0].port_number;
    assign o_res.status      = r_q[0].status;
    assign o_res.run_end     = r_q[0].run_end;

    always_comb begin
        n_state = push ? step_next : r_state;
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt = r_cnt - {1'b0, pop};
        if (push && step_count != 2'd0) begin
            n_q[0] = step_w0;
            n_q[1] = step_w1;
            n_cnt = step_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uhpe_pkg::STATE_RESET;
            r_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule

FILE: tb/url_host_port_extractor_unit_test.sv
// Self-checking testbench for url_host_port_extractor_unit: directed URLs, then random ones.
// A local parser predicts host bytes and random-URL summaries; both channels idle at random.
// Depends on uhpe_pkg, uhpe_if and the unit itself.
module url_host_port_extractor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1100;
    localparam int DIRECTED_COUNT = 27;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 300;

    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_G = 8'h67;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    typedef struct packed {
        logic [7:0]  url_byte;
        logic        eou;
        logic        typed;
        logic [15:0] port;
        logic [1:0]  status;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    uhpe_in_if  url_ch();
    uhpe_out_if res_ch();

    url_host_port_extractor_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_url   (url_ch),
        .o_res   (res_ch)
    );

    uhpe_pkg::t_phase cur_phase;
    logic             scheme_seen;
    logic [1:0]       esc_state;
    logic [3:0]       esc_high;
    logic [15:0]      port_value;
    logic             port_stopped;
    logic [1:0]       url_status;

    uhpe_pkg::t_word  parsed_words[$];
    uhpe_pkg::t_word  due_words[$];
    logic [7:0]       url_text[$];

    int items_sent  = 0;
    int words_taken = 0;
    int fail_count  = 0;
    int cycle_count = 0;
    logic src_steady  = 1'b0;
    logic sink_steady = 1'b0;

    t_stim_row directed_rows[DIRECTED_COUNT] = '{
        '{uhpe_pkg::CH_COLON,   1'b1, 1'b1, 16'd0, uhpe_pkg::ST_NO_SCHEME},
        '{uhpe_pkg::CH_NUL,     1'b1, 1'b1, 16'd0, uhpe_pkg::ST_NO_SCHEME},
        '{8'h61,                1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_COLON,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{8'hFF,                1'b1, 1'b1, 16'd0, uhpe_pkg::ST_NO_SLASH},
        '{8'h73,                1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_COLON,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_SLASH,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_SLASH,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{8'h5A,                1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_PERCENT, 1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{8'h34,                1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{8'h31,                1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_PERCENT, 1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{CH_DIGIT0,            1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{CH_DIGIT0,            1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_COLON,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{CH_DIGIT9,            1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{CH_DIGIT9,            1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{CH_DIGIT9,            1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{CH_DIGIT9,            1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{CH_DIGIT9,            1'b1, 1'b1, uhpe_pkg::PORT_MAX, uhpe_pkg::ST_BAD_ENC},
        '{8'h73,                1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_COLON,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_SLASH,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_SLASH,   1'b0, 1'b0, 16'd0, uhpe_pkg::ST_OK},
        '{uhpe_pkg::CH_SLASH,   1'b1, 1'b1, 16'd0, uhpe_pkg::ST_OK}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void flag_failure(string msg);
        if (fail_count < 10) begin
            $display("%s", msg);
        end
        fail_count++;
    endfunction

    function automatic void clear_parser();
        cur_phase    = uhpe_pkg::PH_SCHEME;
        scheme_seen  = 1'b0;
        esc_state    = uhpe_pkg::ESC_NONE;
        esc_high     = 4'd0;
        port_value   = 16'd0;
        port_stopped = 1'b0;
        url_status   = uhpe_pkg::ST_OK;
    endfunction

    function automatic void note_error(logic [1:0] code);
        if (url_status == uhpe_pkg::ST_OK) begin
            url_status = code;
        end
    endfunction

    function automatic void close_string();
        if (cur_phase == uhpe_pkg::PH_SCHEME) begin
            note_error(uhpe_pkg::ST_NO_SCHEME);
        end else if (cur_phase == uhpe_pkg::PH_SLASH1 || cur_phase == uhpe_pkg::PH_SLASH2) begin
            note_error(uhpe_pkg::ST_NO_SLASH);
        end else if (cur_phase == uhpe_pkg::PH_HOST && esc_state != uhpe_pkg::ESC_NONE) begin
            note_error(uhpe_pkg::ST_BAD_ENC);
        end
        esc_state = uhpe_pkg::ESC_NONE;
        cur_phase = uhpe_pkg::PH_DONE;
    endfunction

    function automatic void emit_word(logic kind, logic [7:0] ch, logic [15:0] port,
                                      logic [1:0] status);
        uhpe_pkg::t_word w;
        w.kind        = kind;
        w.host_char   = ch;
        w.port_number = port;
        w.status      = status;
        w.run_end     = 1'b0;
        parsed_words.push_back(w);
    endfunction

    // Advances the local parser by one byte and leaves the words it causes in parsed_words.
    function automatic void parse_url_byte(logic [7:0] b, logic eou);
        logic [7:0]      c;
        logic [3:0]      nib;
        logic            hex_ok;
        int unsigned     p;
        uhpe_pkg::t_word w;
        parsed_words.delete();
        c = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + uhpe_pkg::CASE_DELTA : b;
        hex_ok = 1'b1;
        nib = 4'd0;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
            nib = 4'(c - CH_DIGIT0);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            nib = 4'(c - CH_LOWER_A + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
        if (b == uhpe_pkg::CH_NUL && cur_phase != uhpe_pkg::PH_DONE) begin
            close_string();
        end else begin
            case (cur_phase)
                uhpe_pkg::PH_SCHEME: begin
                    if (b != uhpe_pkg::CH_COLON) begin
                        scheme_seen = 1'b1;
                    end else if (scheme_seen) begin
                        cur_phase = uhpe_pkg::PH_SLASH1;
                    end else begin
                        note_error(uhpe_pkg::ST_NO_SCHEME);
                        cur_phase = uhpe_pkg::PH_DONE;
                    end
                end
                uhpe_pkg::PH_SLASH1, uhpe_pkg::PH_SLASH2: begin
                    if (b == uhpe_pkg::CH_SLASH) begin
                        cur_phase = (cur_phase == uhpe_pkg::PH_SLASH1) ?
                                    uhpe_pkg::PH_SLASH2 : uhpe_pkg::PH_HOST;
                    end else begin
                        note_error(uhpe_pkg::ST_NO_SLASH);
                        cur_phase = uhpe_pkg::PH_DONE;
                    end
                end
                uhpe_pkg::PH_HOST: begin
                    if (b == uhpe_pkg::CH_SLASH || b == uhpe_pkg::CH_COLON) begin
                        if (esc_state != uhpe_pkg::ESC_NONE) begin
                            note_error(uhpe_pkg::ST_BAD_ENC);
                        end
                        esc_state = uhpe_pkg::ESC_NONE;
                        cur_phase = (b == uhpe_pkg::CH_SLASH) ?
                                    uhpe_pkg::PH_TAIL : uhpe_pkg::PH_PORT;
                    end else if (esc_state == uhpe_pkg::ESC_NONE) begin
                        if (c == uhpe_pkg::CH_PERCENT) begin
                            esc_state = uhpe_pkg::ESC_PCT;
                        end else if (url_status == uhpe_pkg::ST_OK) begin
                            emit_word(uhpe_pkg::KIND_HOST, c, 16'd0, uhpe_pkg::ST_OK);
                        end
                    end else if (!hex_ok) begin
                        note_error(uhpe_pkg::ST_BAD_ENC);
                        esc_state = uhpe_pkg::ESC_NONE;
                    end else if (esc_state == uhpe_pkg::ESC_PCT) begin
                        esc_high  = nib;
                        esc_state = uhpe_pkg::ESC_DIGIT;
                    end else begin
                        esc_state = uhpe_pkg::ESC_NONE;
                        if ({esc_high, nib} == uhpe_pkg::CH_NUL) begin
                            note_error(uhpe_pkg::ST_BAD_ENC);
                        end else if (url_status == uhpe_pkg::ST_OK) begin
                            emit_word(uhpe_pkg::KIND_HOST, {esc_high, nib}, 16'd0,
                                      uhpe_pkg::ST_OK);
                        end
                    end
                end
                uhpe_pkg::PH_PORT: begin
                    if (b == uhpe_pkg::CH_SLASH) begin
                        cur_phase = uhpe_pkg::PH_TAIL;
                    end else if (b >= CH_DIGIT0 && b <= CH_DIGIT9 && !port_stopped) begin
                        p = port_value * 10 + (b - CH_DIGIT0);
                        port_value = (p > uhpe_pkg::PORT_MAX) ? uhpe_pkg::PORT_MAX : p[15:0];
                    end else begin
                        port_stopped = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (eou) begin
            close_string();
            emit_word(uhpe_pkg::KIND_SUMMARY, 8'd0, port_value, url_status);
            clear_parser();
        end
        if (parsed_words.size() > 0) begin
            w = parsed_words.pop_back();
            w.run_end = 1'b1;
            parsed_words.push_back(w);
        end
    endfunction

    task automatic offer_byte(input t_stim_row row);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            src_steady = !src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            url_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        url_ch.valid      <= 1'b1;
        url_ch.url_byte   <= row.url_byte;
        url_ch.end_of_url <= row.eou;
        @(posedge i_clk);
        while (url_ch.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
        parse_url_byte(row.url_byte, row.eou);
        if (row.typed) begin
            due_words.push_back('{uhpe_pkg::KIND_SUMMARY, 8'd0, row.port, row.status, 1'b1});
        end else begin
            foreach (parsed_words[j]) begin
                due_words.push_back(parsed_words[j]);
            end
        end
    endtask

    function automatic logic [7:0] any_letter();
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_DIGIT0 + 8'(nib);
        end
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(nib - 4'd10);
    endfunction

    function automatic void add_host_piece();
        logic [3:0] hi;
        logic [3:0] lo;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: url_text.push_back(any_letter());
            4: url_text.push_back(CH_DIGIT0 + 8'($urandom_range(0, 9)));
            5, 6: begin
                hi = 4'($urandom_range(0, 15));
                lo = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 7) == 0) begin
                    hi = 4'd0;
                    lo = 4'd0;
                end
                url_text.push_back(uhpe_pkg::CH_PERCENT);
                url_text.push_back(hex_char(hi));
                url_text.push_back(hex_char(lo));
            end
            7: begin
                url_text.push_back(uhpe_pkg::CH_PERCENT);
                if ($urandom_range(0, 1) == 0) begin
                    url_text.push_back(hex_char(4'($urandom_range(0, 15))));
                end
                case ($urandom_range(0, 5))
                    0: url_text.push_back(uhpe_pkg::CH_SLASH);
                    1: url_text.push_back(uhpe_pkg::CH_COLON);
                    default: url_text.push_back(CH_LOWER_G + 8'($urandom_range(0, 19)));
                endcase
            end
            default: url_text.push_back(8'($urandom_range(1, 255)));
        endcase
    endfunction

    // Mostly well-formed URLs with random content; the rest are noise or have one byte hit.
    function automatic void build_url();
        int shape;
        int n;
        url_text.delete();
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            n = $urandom_range(1, 10);
            repeat (n) url_text.push_back(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) url_text.push_back(any_letter());
            url_text.push_back(uhpe_pkg::CH_COLON);
            url_text.push_back(uhpe_pkg::CH_SLASH);
            url_text.push_back(uhpe_pkg::CH_SLASH);
            n = $urandom_range(0, 8);
            repeat (n) add_host_piece();
            if ($urandom_range(0, 3) != 0) begin
                url_text.push_back(uhpe_pkg::CH_COLON);
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0: url_text.push_back(CH_SPACE);
                        1: url_text.push_back(CH_PLUS);
                        default: url_text.push_back(CH_MINUS);
                    endcase
                end
                n = $urandom_range(0, 6);
                repeat (n) url_text.push_back(CH_DIGIT0 + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 7) == 0) begin
                    url_text.push_back(any_letter());
                    url_text.push_back(CH_DIGIT0 + 8'($urandom_range(0, 9)));
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                url_text.push_back(uhpe_pkg::CH_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) url_text.push_back(8'($urandom_range(1, 255)));
            end
            if (shape < 25) begin
                n = $urandom_range(0, url_text.size() - 1);
                url_text[n] = ($urandom_range(0, 3) == 0) ? uhpe_pkg::CH_NUL
                                                           : 8'($urandom_range(0, 255));
            end
        end
    endfunction

    initial begin
        i_rst_n           <= 1'b0;
        url_ch.valid      <= 1'b0;
        url_ch.url_byte   <= 8'd0;
        url_ch.end_of_url <= 1'b0;
        res_ch.ready      <= 1'b0;
        clear_parser();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i]) begin
            offer_byte(directed_rows[i]);
        end
        while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
            build_url();
            foreach (url_text[k]) begin
                offer_byte('{url_text[k], k == url_text.size() - 1, 1'b0, 16'd0,
                             uhpe_pkg::ST_OK});
            end
        end
        url_ch.valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // The result side stalls at random, and twice holds off long enough to back up the input.
    initial begin
        int stall;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                sink_steady = !sink_steady;
            end
            stall = sink_steady ? 0 : $urandom_range(0, 14);
            if (words_taken == 30 || words_taken == 200) begin
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (res_ch.valid !== 1'b1) @(posedge i_clk);
            words_taken++;
        end
    end

    always @(posedge i_clk) begin
        uhpe_pkg::t_word got;
        uhpe_pkg::t_word want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got = '{res_ch.kind, res_ch.host_char, res_ch.port_number, res_ch.status,
                    res_ch.run_end};
            if (due_words.size() == 0) begin
                flag_failure($sformatf({"Unexpected word at %0t: kind %0d char %h port %0d ",
                    "st %0d end %0d"}, $time, got.kind, got.host_char, got.port_number,
                    got.status, got.run_end));
            end else begin
                want = due_words.pop_front();
                if (got !== want) begin
                    flag_failure($sformatf({"Mismatch at %0t: expected kind %0d char %h port %0d ",
                        "st %0d end %0d, got kind %0d char %h port %0d st %0d end %0d"}, $time,
                        want.kind, want.host_char, want.port_number, want.status, want.run_end,
                        got.kind, got.host_char, got.port_number, got.status, got.run_end));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
